[src/btcw_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the bordered text console writer
// no dependencies

package btcw_pkg;

  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  localparam int CmdW    = 2;
  localparam int CharW   = 8;
  localparam int ColorW  = 8;
  localparam int ColPortW = 7;
  localparam int RowPortW = 5;
  localparam int CellW   = CharW + ColorW;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  localparam logic [CharW-1:0]  ChBar     = 8'h7C;
  localparam logic [CharW-1:0]  ChDash    = 8'h2D;
  localparam logic [CharW-1:0]  ChSpace   = 8'h20;
  localparam logic [CharW-1:0]  ChNewline = 8'h0A;
  localparam logic [ColorW-1:0] ResetColor = 8'h02;

  typedef enum logic [CmdW-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_TEXT_COLOR   = 1'b0,
    REG_BORDER_COLOR = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_FRAME,
    S_IDLE,
    S_RD,
    S_PUT_A,
    S_PUT_B,
    S_PUT_C,
    S_PUT_D,
    S_SCR,
    S_SCR_LAST,
    S_BLANK,
    S_RESP
  } state_e;

endpackage

[src/bordered_text_console_writer_core.sv]
`timescale 1ns / 1ps
// text console engine: screen memory, cursor, scroll and frame sequencer
// depends on btcw_pkg
// read via S_RD, put S_PUT_A, S_PUT_C (margins add S_PUT_B, S_PUT_D), newline may scroll
// scroll: copy up in S_SCR and S_SCR_LAST, blank bottom row in S_BLANK, one cell a cycle
// clear: redraws the frame, one cell write a cycle through the single memory write port
// one word in flight at a time; a finished result waits in the output register
// reset: frame drawn by a sweep of every cell, input stalled meanwhile, config open

module bordered_text_console_writer_core
  import btcw_pkg::*;
#(
  parameter int COLUMNS = DefColumns,
  parameter int ROWS    = DefRows
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [CharW-1:0]    char_code_i,
  input  logic [ColPortW-1:0] read_col_i,
  input  logic [RowPortW-1:0] read_row_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CharW-1:0]    cell_char_o,
  output logic [ColorW-1:0]   cell_color_o,
  output logic [RowPortW-1:0] cursor_line_o,
  output logic [ColPortW-1:0] cursor_col_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + CW;
  localparam int Depth = 2 ** AW;

  localparam logic [CW-1:0] ColM1 = CW'(COLUMNS - 1);
  localparam logic [CW-1:0] ColM2 = CW'(COLUMNS - 2);
  localparam logic [CW-1:0] ColM3 = CW'(COLUMNS - 3);
  localparam logic [CW-1:0] ColTwo = CW'(2);
  localparam logic [CW:0]   ColEnd = (CW + 1)'(COLUMNS);
  localparam logic [RW-1:0] RowM1 = RW'(ROWS - 1);
  localparam logic [RW-1:0] RowM2 = RW'(ROWS - 2);
  localparam logic [RW-1:0] RowTwo = RW'(2);
  localparam logic [RW:0]   RowLast = (RW + 1)'(ROWS - 1);

  // configuration
  logic [ColorW-1:0] text_q, border_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q   <= ResetColor;
      border_q <= ResetColor;
    end else if (cfg_we) begin
      case (reg_e'(paddr[2]))
        REG_TEXT_COLOR:   text_q   <= pwdata[ColorW-1:0];
        REG_BORDER_COLOR: border_q <= pwdata[ColorW-1:0];
        default:          text_q   <= text_q;
      endcase
    end
  end

  assign prdata = (reg_e'(paddr[2]) == REG_BORDER_COLOR) ?
                  ApbDataW'(border_q) : ApbDataW'(text_q);

  // screen memory
  logic [CellW-1:0] mem_q [Depth];
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [CellW-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // control registers
  state_e            state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     sy_q, sy_d;
  logic [CW-1:0]     sx_q, sx_d;
  logic              cp_pend_q, cp_pend_d;
  logic [AW-1:0]     cp_addr_q, cp_addr_d;
  logic              scr_ret_q, scr_ret_d;
  logic              init_q, init_d;
  logic              rd_ok_q, rd_ok_d;
  logic [CharW-1:0]  ch_q, ch_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  cell_char_q, cell_char_d;
  logic [ColorW-1:0] cell_color_q, cell_color_d;
  logic [RW-1:0]     cur_row_q, cur_row_d;
  logic [CW-1:0]     cur_col_q, cur_col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FRAME;
      row_q       <= RW'(1);
      col_q       <= '0;
      sy_q        <= '0;
      sx_q        <= '0;
      cp_pend_q   <= 1'b0;
      scr_ret_q   <= 1'b0;
      init_q      <= 1'b1;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      sy_q        <= sy_d;
      sx_q        <= sx_d;
      cp_pend_q   <= cp_pend_d;
      scr_ret_q   <= scr_ret_d;
      init_q      <= init_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q    <= cp_addr_d;
    ch_q         <= ch_d;
    cell_char_q  <= cell_char_d;
    cell_color_q <= cell_color_d;
    cur_row_q    <= cur_row_d;
    cur_col_q    <= cur_col_d;
  end

  // cursor helpers
  logic [RW:0]       row_inc;
  logic              row_wrap;
  logic [RW-1:0]     row_next;
  logic [CW:0]       col_inc;
  logic              col_wrap;
  logic [RW-1:0]     sy_m1;
  logic [ColorW-1:0] frm_text, frm_border;
  logic [CellW-1:0]  frame_cell;
  logic              in_acc;
  logic [RW-1:0]     rd_row;
  logic [CW-1:0]     rd_col;
  logic              rd_in_range;

  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign row_wrap = (row_inc >= RowLast);
  assign row_next = row_wrap ? RowM2 : row_inc[RW-1:0];
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign col_wrap = (col_inc == ColEnd);
  assign sy_m1    = sy_q - 1'b1;

  assign frm_text   = init_q ? ResetColor : text_q;
  assign frm_border = init_q ? ResetColor : border_q;

  always_comb begin
    if (sy_q == '0 || sy_q == RowM1) begin
      frame_cell = {frm_border, ChDash};
    end else if (sx_q == '0 || sx_q == ColM1) begin
      frame_cell = {frm_border, ChBar};
    end else if (sx_q == CW'(1) || sx_q == ColM2) begin
      frame_cell = {frm_border, ChSpace};
    end else begin
      frame_cell = {frm_text, ChSpace};
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign rd_row      = RW'(read_row_i);
  assign rd_col      = CW'(read_col_i);
  assign rd_in_range = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLUMNS);

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    sy_d         = sy_q;
    sx_d         = sx_q;
    cp_pend_d    = cp_pend_q;
    cp_addr_d    = cp_addr_q;
    scr_ret_d    = scr_ret_q;
    init_d       = init_q;
    rd_ok_d      = rd_ok_q;
    ch_d         = ch_q;
    cell_char_d  = cell_char_q;
    cell_color_d = cell_color_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    out_valid_d  = out_valid_q & out_stall_i;
    we           = 1'b0;
    waddr        = {row_q, col_q};
    wdata        = {text_q, ch_q};
    raddr        = {sy_q, sx_q};

    case (state_q)
      S_FRAME: begin
        we    = 1'b1;
        waddr = {sy_q, sx_q};
        wdata = frame_cell;
        if (sx_q == ColM1) begin
          sx_d = '0;
          if (sy_q == RowM1) begin
            init_d  = 1'b0;
            state_d = init_q ? S_IDLE : S_RESP;
          end else begin
            sy_d = sy_q + 1'b1;
          end
        end else begin
          sx_d = sx_q + 1'b1;
        end
      end

      S_IDLE: begin
        raddr = {rd_row, rd_col};
        if (in_acc) begin
          ch_d    = char_code_i;
          rd_ok_d = 1'b0;
          case (cmd_e'(cmd_i))
            CMD_PUT: begin
              if (char_code_i == ChNewline) begin
                col_d = '0;
                row_d = row_next;
                if (row_wrap) begin
                  sy_d      = RowTwo;
                  sx_d      = ColTwo;
                  cp_pend_d = 1'b0;
                  scr_ret_d = 1'b0;
                  state_d   = S_SCR;
                end else begin
                  state_d = S_RESP;
                end
              end else begin
                state_d = S_PUT_A;
              end
            end
            CMD_READ: begin
              rd_ok_d = rd_in_range;
              sy_d    = rd_row;
              sx_d    = rd_col;
              state_d = S_RD;
            end
            CMD_CLEAR: begin
              sy_d    = '0;
              sx_d    = '0;
              state_d = S_FRAME;
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_RD: begin
        state_d = S_RESP;
      end

      // right margin
      S_PUT_A: begin
        if (col_q == ColM2) begin
          we      = 1'b1;
          wdata   = {border_q, ChSpace};
          col_d   = col_inc[CW-1:0];
          state_d = S_PUT_B;
        end else begin
          state_d = S_PUT_C;
        end
      end

      S_PUT_B: begin
        we    = 1'b1;
        wdata = {border_q, ChBar};
        col_d = '0;
        row_d = row_next;
        if (row_wrap) begin
          sy_d      = RowTwo;
          sx_d      = ColTwo;
          cp_pend_d = 1'b0;
          scr_ret_d = 1'b1;
          state_d   = S_SCR;
        end else begin
          state_d = S_PUT_C;
        end
      end

      // left margin or the character itself
      S_PUT_C: begin
        we = 1'b1;
        if (col_q == '0) begin
          wdata   = {border_q, ChBar};
          col_d   = CW'(1);
          state_d = S_PUT_D;
        end else begin
          wdata = {text_q, ch_q};
          if (col_wrap) begin
            col_d = '0;
            row_d = row_next;
            if (row_wrap) begin
              sy_d      = RowTwo;
              sx_d      = ColTwo;
              cp_pend_d = 1'b0;
              scr_ret_d = 1'b0;
              state_d   = S_SCR;
            end else begin
              state_d = S_RESP;
            end
          end else begin
            col_d   = col_inc[CW-1:0];
            state_d = S_RESP;
          end
        end
      end

      S_PUT_D: begin
        we      = 1'b1;
        wdata   = {border_q, ChSpace};
        col_d   = ColTwo;
        state_d = S_PUT_C;
      end

      // copy pipeline: read one row down, write back one row up in the following cycle
      S_SCR: begin
        raddr     = {sy_q, sx_q};
        we        = cp_pend_q;
        waddr     = cp_addr_q;
        wdata     = rdata_q;
        cp_pend_d = 1'b1;
        cp_addr_d = {sy_m1, sx_q};
        if (sx_q == ColM3) begin
          sx_d = ColTwo;
          if (sy_q == RowM2) begin
            state_d = S_SCR_LAST;
          end else begin
            sy_d = sy_q + 1'b1;
          end
        end else begin
          sx_d = sx_q + 1'b1;
        end
      end

      S_SCR_LAST: begin
        we        = cp_pend_q;
        waddr     = cp_addr_q;
        wdata     = rdata_q;
        cp_pend_d = 1'b0;
        sx_d      = ColTwo;
        state_d   = S_BLANK;
      end

      S_BLANK: begin
        we    = 1'b1;
        waddr = {RowM2, sx_q};
        wdata = {text_q, ChSpace};
        if (sx_q == ColM3) begin
          state_d = scr_ret_q ? S_PUT_C : S_RESP;
        end else begin
          sx_d = sx_q + 1'b1;
        end
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          cell_char_d  = rd_ok_q ? rdata_q[CharW-1:0] : '0;
          cell_color_d = rd_ok_q ? rdata_q[CellW-1:CharW] : '0;
          cur_row_d    = row_q;
          cur_col_d    = col_q;
          rd_ok_d      = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // read data stays in rdata_q through S_RESP since raddr is parked on the sweep counters
  assign out_valid_o   = out_valid_q;
  assign cell_char_o   = cell_char_q;
  assign cell_color_o  = cell_color_q;
  assign cursor_line_o = RowPortW'(cur_row_q);
  assign cursor_col_o  = ColPortW'(cur_col_q);

endmodule
